/* src/rlfe_pkg.sv */
// rlfe_pkg: shared types and constants for the RGB LED fade engine.
// No dependencies.
package rlfe_pkg;

    localparam int NUM_LEDS_DEF    = 16;
    localparam int TICK_PERIOD_RST = 10;
    localparam int GAIN_SHIFT      = 10;
    localparam int CH_MAX          = 255;

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SET_RD,
        S_SET_LAT,
        S_SET_DIV,
        S_TICK_RD,
        S_TICK_LAT,
        S_TICK_EVAL,
        S_TICK_MUL,
        S_TICK_DIV,
        S_TICK_NEXT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_OUT
    } state_t;

    // one LED's fade record, channel order r, g, b
    typedef struct packed {
        logic [2:0][7:0] pix;
        logic [2:0][7:0] start;
        logic [2:0][7:0] tgt;
        logic [15:0]     elapsed;
        logic [15:0]     len;
    } entry_t;

endpackage

/* src/rlfe_div.sv */
// rlfe_div: restoring shift-subtract divider, one quotient bit per cycle.
// Uses rlfe_pkg for house conventions only.
module rlfe_div
    import rlfe_pkg::*;
#(
    parameter int N = 16,   // dividend width
    parameter int D = 10,   // divisor width
    parameter int Q = 16    // quotient bits; dividend must stay below divisor << Q
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [Q-1:0] quotient
);

    localparam int W  = (N > D + Q - 1) ? N : D + Q - 1;
    localparam int CW = $clog2(Q + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsh_reg;
    logic [Q-1:0]  q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(Q);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= W'(dividend);
            dsh_reg <= W'(divisor) << (Q - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            q_reg   <= {q_reg[Q-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

/* src/rgb_led_fade_engine.sv */
// rgb_led_fade_engine: per-LED linear RGB fade table with frame output.
// Depends on rlfe_pkg and rlfe_div.
//
// One request is handled at a time. A set request waits on the 16-step
// divider that turns fade_ms into a tick count. A tick request sweeps the
// LED table held in one memory (registered read), LED by LED; a fading LED
// short of its end also waits on the 8-step channel dividers. It then emits
// a frame of NUM_LEDS results, each read from the table and held until taken,
// so the output can stall the frame. A tick that changes nothing and follows
// no set emits no frame. The configuration write is always ready.
module rgb_led_fade_engine
    import rlfe_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  led_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [15:0] brightness,
    input  logic [15:0] fade_ms,
    input  logic [7:0]  tick_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pixel_index,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEDS - 1);

    state_t state_reg, state_next;

    entry_t        mem [NUM_LEDS];
    logic          vld_reg [NUM_LEDS];
    logic [IW-1:0] rd_addr;
    entry_t        rd_data_reg;
    logic          rd_vld_reg;
    entry_t        rd_entry;
    logic          wr_en;
    entry_t        wr_data;

    logic [IW-1:0]  idx_reg;
    logic [2:0][7:0] col_in_reg;
    logic [15:0]    bright_reg;
    logic [15:0]    fms_reg;
    logic [7:0]     adv_reg;
    logic [9:0]     period_reg;
    logic           dirty_reg;
    logic           changed_reg;
    entry_t         ent_reg;
    logic [2:0][7:0] tgt_reg;
    logic [15:0]    e_reg;

    logic           in_acc;
    logic           out_acc;
    logic           out_valid_reg;
    logic [5:0]     pix_idx_reg;
    logic [2:0][7:0] pix_out_reg;
    logic           last_reg;

    // dividers
    logic           len_start;
    logic           len_busy;
    logic [15:0]    len_q;
    logic [9:0]     per_eff;
    logic           ch_start;
    logic [2:0]     ch_busy;
    logic [2:0][7:0] ch_q;
    logic [2:0][23:0] ch_num;
    logic [2:0]     ch_up;

    logic [16:0]    e_sum;
    logic [15:0]    e_clamp;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid_reg && out_ready;
    assign per_eff   = (period_reg == 10'd0) ? 10'd1 : period_reg;
    assign rd_entry  = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= 10'(TICK_PERIOD_RST);
        else if (cfg_valid && cfg_ready)
            period_reg <= cfg_data;
    end

    // LED table memory; entries never written read as zero via valid bits
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
                vld_reg[i] <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[idx_reg] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    rlfe_div #(.N(16), .D(10), .Q(16)) u_len_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (len_start),
        .dividend (fms_reg),
        .divisor  (per_eff),
        .busy     (len_busy),
        .quotient (len_q)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        assign ch_up[c]  = (ent_reg.tgt[c] >= ent_reg.start[c]);
        assign ch_num[c] = 24'(ch_up[c] ? 8'(ent_reg.tgt[c] - ent_reg.start[c])
                                        : 8'(ent_reg.start[c] - ent_reg.tgt[c]))
                           * 24'(e_reg);
        rlfe_div #(.N(24), .D(16), .Q(8)) u_ch_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (ch_start),
            .dividend (ch_num[c]),
            .divisor  (ent_reg.len),
            .busy     (ch_busy[c]),
            .quotient (ch_q[c])
        );
    end

    assign e_sum   = {1'b0, ent_reg.elapsed} + 17'(adv_reg);
    assign e_clamp = (e_sum > {1'b0, ent_reg.len}) ? ent_reg.len : e_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_data    = ent_reg;
        len_start  = 1'b0;
        ch_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_SET)
                    begin
                        if (led_index < 8'(NUM_LEDS))
                            state_next = S_SET_RD;
                    end
                    else if (tick_count != 8'd0 || dirty_reg)
                        state_next = S_TICK_RD;
                end
            end
            S_SET_RD:
            begin
                len_start  = 1'b1;
                state_next = S_SET_LAT;
            end
            S_SET_LAT:
                state_next = S_SET_DIV;
            S_SET_DIV:
            begin
                if (!len_busy)
                begin
                    wr_en         = 1'b1;
                    wr_data.start = ent_reg.pix;
                    wr_data.tgt   = tgt_reg;
                    wr_data.elapsed = 16'd0;
                    if (fms_reg == 16'd0)
                    begin
                        wr_data.pix = tgt_reg;
                        wr_data.len = 16'd0;
                    end
                    else
                        wr_data.len = (len_q == 16'd0) ? 16'd1 : len_q;
                    state_next = S_IDLE;
                end
            end
            S_TICK_RD:
                state_next = S_TICK_LAT;
            S_TICK_LAT:
                state_next = S_TICK_EVAL;
            S_TICK_EVAL:
            begin
                if (ent_reg.elapsed < ent_reg.len)
                begin
                    if (e_clamp == ent_reg.len)
                    begin
                        wr_en           = 1'b1;
                        wr_data.elapsed = e_clamp;
                        wr_data.pix     = ent_reg.tgt;
                        state_next      = S_TICK_NEXT;
                    end
                    else
                        state_next = S_TICK_MUL;
                end
                else
                begin
                    if (ent_reg.len != 16'd0)
                    begin
                        wr_en       = 1'b1;
                        wr_data.pix = ent_reg.tgt;
                        wr_data.len = 16'd0;
                    end
                    state_next = S_TICK_NEXT;
                end
            end
            S_TICK_MUL:
            begin
                ch_start   = 1'b1;
                state_next = S_TICK_DIV;
            end
            S_TICK_DIV:
            begin
                if (ch_busy == 3'b000)
                begin
                    wr_en           = 1'b1;
                    wr_data.elapsed = e_reg;
                    for (int c = 0; c < 3; c++)
                        wr_data.pix[c] = ch_up[c] ? 8'(ent_reg.start[c] + ch_q[c])
                                                  : 8'(ent_reg.start[c] - ch_q[c]);
                    state_next = S_TICK_NEXT;
                end
            end
            S_TICK_NEXT:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = (changed_reg || dirty_reg) ? S_EMIT_RD : S_IDLE;
                else
                    state_next = S_TICK_RD;
            end
            S_EMIT_RD:
                state_next = S_EMIT_LD;
            S_EMIT_LD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_acc)
                    state_next = last_reg ? S_IDLE : S_EMIT_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            dirty_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (req_type == REQ_SET)
                        begin
                            idx_reg <= IW'(led_index);
                            if (led_index < 8'(NUM_LEDS))
                                dirty_reg <= 1'b1;
                        end
                        else
                            idx_reg <= '0;
                        changed_reg <= 1'b0;
                    end
                end
                S_TICK_EVAL:
                begin
                    if (ent_reg.elapsed < ent_reg.len)
                        changed_reg <= 1'b1;
                    else if (ent_reg.len != 16'd0 && ent_reg.pix != ent_reg.tgt)
                        changed_reg <= 1'b1;
                end
                S_TICK_NEXT:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        dirty_reg <= 1'b0;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_EMIT_LD:
                    out_valid_reg <= 1'b1;
                S_EMIT_OUT:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        if (!last_reg)
                            idx_reg <= idx_reg + IW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            col_in_reg <= {blue_in, green_in, red_in};
            bright_reg <= brightness;
            fms_reg    <= fade_ms;
            adv_reg    <= tick_count;
        end
        if (state_reg == S_SET_RD)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [23:0] prod;
                prod = 24'(col_in_reg[c]) * 24'(bright_reg);
                tgt_reg[c] <= (|prod[23:GAIN_SHIFT+8]) ? 8'(CH_MAX)
                                                       : prod[GAIN_SHIFT+7:GAIN_SHIFT];
            end
        end
        if (state_reg == S_SET_LAT || state_reg == S_TICK_LAT)
            ent_reg <= rd_entry;
        if (state_reg == S_TICK_EVAL)
            e_reg <= e_clamp;
        if (state_reg == S_EMIT_LD)
        begin
            pix_idx_reg <= 6'(idx_reg);
            pix_out_reg <= rd_entry.pix;
            last_reg    <= (idx_reg == LAST_IDX);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_idx_reg;
    assign red_out     = pix_out_reg[0];
    assign green_out   = pix_out_reg[1];
    assign blue_out    = pix_out_reg[2];
    assign frame_last  = last_reg;

endmodule

/* src/rlfe_checker.sv */
// rlfe_checker: port-level assertions for rgb_led_fade_engine.
// Depends on rlfe_pkg; bound to the top level below.
module rlfe_checker
    import rlfe_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  pixel_index,
    input logic        frame_last
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // no request is taken while a frame is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("request taken during frame output");

    // frame end marks the last LED
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> pixel_index == 6'(NUM_LEDS - 1))
        else $error("frame_last on wrong LED");

    // mid-frame, the block keeps refusing requests
    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !frame_last |=> !in_ready)
        else $error("frame cut short");

endmodule

bind rgb_led_fade_engine rlfe_checker #(.NUM_LEDS(NUM_LEDS)) u_rlfe_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_index (pixel_index),
    .frame_last  (frame_last)
);
